@@ design/clcd_pkg.sv @@
// Shared types and constants of the character-LCD command sequencer.
`timescale 1ns / 1ps

package clcd_pkg;

  // Display geometry
  localparam int unsigned MaxRows   = 4;
  localparam logic [1:0]  MaxRowIdx = 2'(MaxRows - 1);

  // Command codes on the input side
  localparam logic [4:0] FnInit      = 5'd0;
  localparam logic [4:0] FnClear     = 5'd1;
  localparam logic [4:0] FnHome      = 5'd2;
  localparam logic [4:0] FnCursorPos = 5'd3;
  localparam logic [4:0] FnDispOn    = 5'd4;
  localparam logic [4:0] FnDispOff   = 5'd5;
  localparam logic [4:0] FnCursorOn  = 5'd6;
  localparam logic [4:0] FnCursorOff = 5'd7;
  localparam logic [4:0] FnBlinkOn   = 5'd8;
  localparam logic [4:0] FnBlinkOff  = 5'd9;
  localparam logic [4:0] FnScrollL   = 5'd10;
  localparam logic [4:0] FnScrollR   = 5'd11;
  localparam logic [4:0] FnLtoR      = 5'd12;
  localparam logic [4:0] FnRtoL      = 5'd13;
  localparam logic [4:0] FnAutoOn    = 5'd14;
  localparam logic [4:0] FnAutoOff   = 5'd15;
  localparam logic [4:0] FnChar      = 5'd16;

  // Configuration register indexes
  localparam logic [1:0] CfgColumns  = 2'd0;
  localparam logic [1:0] CfgRows     = 2'd1;
  localparam logic [1:0] CfgTallFont = 2'd2;
  localparam logic [1:0] CfgBus8     = 2'd3;

  localparam logic [5:0] ColumnsReset = 6'd20;
  localparam logic [2:0] RowsReset    = 3'd2;

  // Controller instruction bytes
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdHome     = 8'h02;
  localparam logic [7:0] CmdEntry    = 8'h04;
  localparam logic [7:0] CmdControl  = 8'h08;
  localparam logic [7:0] CmdScrollL  = 8'h18;
  localparam logic [7:0] CmdScrollR  = 8'h1C;
  localparam logic [7:0] CmdFuncSet  = 8'h20;
  localparam logic [7:0] Func8Bit    = 8'h10;
  localparam logic [7:0] CmdDdram    = 8'h80;
  localparam logic [7:0] WakeByte    = 8'h30;
  localparam logic [7:0] WakeLast    = 8'h20;
  localparam logic [6:0] Row1Offset  = 7'h40;
  localparam logic [2:0] CtrlInit    = 3'b100;
  localparam logic [1:0] EntryInit   = 2'b10;
  localparam logic [7:0] InitDisplay = CmdControl | {5'b0, CtrlInit};
  localparam logic [7:0] InitEntry   = CmdEntry | {6'b0, EntryInit};

  // Pause codes after a strobe
  localparam logic [1:0] PauseNone = 2'd0;
  localparam logic [1:0] Pause1ms  = 2'd1;
  localparam logic [1:0] Pause2ms  = 2'd2;
  localparam logic [1:0] Pause5ms  = 2'd3;

  // Byte slots of the init run; a single-byte command uses the last slot only
  localparam logic [2:0] SlotWake0    = 3'd0;
  localparam logic [2:0] SlotWake1    = 3'd1;
  localparam logic [2:0] SlotWake2    = 3'd2;
  localparam logic [2:0] SlotWakeLast = 3'd3;
  localparam logic [2:0] SlotFuncSet  = 3'd4;
  localparam logic [2:0] SlotDisplay  = 3'd5;
  localparam logic [2:0] SlotClear    = 3'd6;
  localparam logic [2:0] SlotLast     = 3'd7;

  // Command queue geometry
  localparam int unsigned DescDepth = 2;
  localparam int unsigned DescPtrW  = 1;
  localparam int unsigned DescCntW  = 2;

  // Classified command handed from front to back
  typedef struct packed {
    logic       is_init;
    logic       bus8;
    logic       rs;
    logic [7:0] bus_byte;
    logic [1:0] pause;
  } desc_t;

  // One bus transfer
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       pause_before;
    logic [1:0] pause_after;
    logic       last;
  } xfer_t;

endpackage

@@ design/char_lcd_command_sequencer_core.sv @@
// Top level of the character-LCD command sequencer.
`timescale 1ns / 1ps

// Takes character-LCD commands and characters and turns each into a run of
// bus transfers (register select, bus byte, pause codes, end-of-run flag),
// presented one at a time on a queue-style result port. The transfer
// sequencer emits one transfer per clock while the result side pops. A
// character or simple command is 1 transfer on an 8-bit bus and 2 on a
// 4-bit bus, init is 8 or 12 transfers, and codes 17 to 31 are accepted
// with no result. A first result passes through the command queue and the
// result buffer before it shows on the result ports, where it can be popped.
// The front end classifies items and
// updates the shadow state at acceptance, so it keeps taking items while up
// to two commands wait in the queue before the sequencer. Configuration is
// written through a plain write port and should change only while idle.
module char_lcd_command_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  input  logic       push,
  output logic       full,
  input  logic [4:0] func_i,
  input  logic [7:0] char_or_col_i,
  input  logic [7:0] row_number_i,
  output logic       empty,
  input  logic       pop,
  output logic       reg_select_o,
  output logic [7:0] bus_value_o,
  output logic       pause_before_o,
  output logic [1:0] pause_after_o,
  output logic       last_transfer_o
);
  import clcd_pkg::*;

  logic  q_push;
  desc_t q_desc_in;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  desc_t q_desc_out;
  xfer_t xfer;

  assign full = q_full;

  clcd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .func_i        (func_i),
    .char_or_col_i (char_or_col_i),
    .row_number_i  (row_number_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_desc_o      (q_desc_in)
  );

  clcd_desc_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .desc_o  (q_desc_out)
  );

  clcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (q_desc_out),
    .desc_pop_o   (q_pop),
    .pop          (pop),
    .empty        (empty),
    .xfer_o       (xfer)
  );

  assign reg_select_o    = xfer.rs;
  assign bus_value_o     = xfer.value;
  assign pause_before_o  = xfer.pause_before;
  assign pause_after_o   = xfer.pause_after;
  assign last_transfer_o = xfer.last;

endmodule

@@ design/clcd_front.sv @@
// Front end: configuration registers, shadow state and command classification.
`timescale 1ns / 1ps

module clcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i,
  input  logic                push_i,
  input  logic [4:0]          func_i,
  input  logic [7:0]          char_or_col_i,
  input  logic [7:0]          row_number_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output clcd_pkg::desc_t     q_desc_o
);
  import clcd_pkg::*;

  logic [5:0] cols_cfg_q;
  logic [2:0] rows_cfg_q;
  logic       tall_cfg_q;
  logic       bus8_cfg_q;

  logic [1:0] func_bits_q, func_bits_d;
  logic [2:0] ctrl_bits_q, ctrl_bits_d;
  logic [1:0] entry_bits_q, entry_bits_d;
  logic [2:0] rows_use_q, rows_use_d;
  logic [5:0] cols_lat_q, cols_lat_d;

  logic       accept;
  logic       emit;
  logic [1:0] row_lim;
  logic [1:0] row_sel;
  logic [6:0] row_off;
  logic [2:0] ctrl_bit;
  logic [1:0] entry_bit;

  assign accept = push_i && !q_full_i;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= ColumnsReset;
      rows_cfg_q <= RowsReset;
      tall_cfg_q <= 1'b0;
      bus8_cfg_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgColumns:  cols_cfg_q <= cfg_data_i;
        CfgRows:     rows_cfg_q <= cfg_data_i[2:0];
        CfgTallFont: tall_cfg_q <= cfg_data_i[0];
        CfgBus8:     bus8_cfg_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  // Cursor row clamp and DDRAM row offset
  always_comb begin
    row_lim = (row_number_i > {6'b0, MaxRowIdx}) ? MaxRowIdx : row_number_i[1:0];
    if (rows_use_q == 3'd0) begin
      row_sel = 2'd0;
    end else if ({1'b0, row_lim} >= rows_use_q) begin
      row_sel = 2'(rows_use_q - 3'd1);
    end else begin
      row_sel = row_lim;
    end
    case (row_sel)
      2'd0:    row_off = 7'h00;
      2'd1:    row_off = Row1Offset;
      2'd2:    row_off = {1'b0, cols_lat_q};
      default: row_off = Row1Offset + {1'b0, cols_lat_q};
    endcase
  end

  // Bit picked by the on/off style commands
  always_comb begin
    if (func_i <= FnDispOff) begin
      ctrl_bit = 3'b100;
    end else if (func_i <= FnCursorOff) begin
      ctrl_bit = 3'b010;
    end else begin
      ctrl_bit = 3'b001;
    end
    entry_bit = (func_i <= FnRtoL) ? 2'b10 : 2'b01;
  end

  // Classification and shadow state update
  always_comb begin
    func_bits_d  = func_bits_q;
    ctrl_bits_d  = ctrl_bits_q;
    entry_bits_d = entry_bits_q;
    rows_use_d   = rows_use_q;
    cols_lat_d   = cols_lat_q;
    emit              = 1'b1;
    q_desc_o.is_init  = 1'b0;
    q_desc_o.bus8     = bus8_cfg_q;
    q_desc_o.rs       = 1'b0;
    q_desc_o.bus_byte = 8'h00;
    q_desc_o.pause    = PauseNone;
    case (func_i)
      FnInit: begin
        func_bits_d = func_bits_q
                    | {rows_cfg_q > 3'd1, tall_cfg_q && (rows_cfg_q == 3'd1)};
        rows_use_d   = rows_cfg_q;
        cols_lat_d   = cols_cfg_q;
        ctrl_bits_d  = CtrlInit;
        entry_bits_d = EntryInit;
        q_desc_o.is_init  = 1'b1;
        q_desc_o.bus_byte = CmdFuncSet | (bus8_cfg_q ? Func8Bit : 8'h00)
                          | {4'b0, func_bits_d, 2'b00};
      end
      FnClear: begin
        q_desc_o.bus_byte = CmdClear;
        q_desc_o.pause    = Pause2ms;
      end
      FnHome: begin
        q_desc_o.bus_byte = CmdHome;
        q_desc_o.pause    = Pause2ms;
      end
      FnCursorPos: begin
        q_desc_o.bus_byte = CmdDdram | {1'b0, 7'(char_or_col_i[6:0] + row_off)};
      end
      FnDispOn, FnDispOff, FnCursorOn, FnCursorOff, FnBlinkOn, FnBlinkOff: begin
        ctrl_bits_d = func_i[0] ? (ctrl_bits_q & ~ctrl_bit) : (ctrl_bits_q | ctrl_bit);
        q_desc_o.bus_byte = CmdControl | {5'b0, ctrl_bits_d};
      end
      FnScrollL: q_desc_o.bus_byte = CmdScrollL;
      FnScrollR: q_desc_o.bus_byte = CmdScrollR;
      FnLtoR, FnRtoL, FnAutoOn, FnAutoOff: begin
        entry_bits_d = func_i[0] ? (entry_bits_q & ~entry_bit)
                                 : (entry_bits_q | entry_bit);
        q_desc_o.bus_byte = CmdEntry | {6'b0, entry_bits_d};
      end
      FnChar: begin
        q_desc_o.rs       = 1'b1;
        q_desc_o.bus_byte = char_or_col_i;
      end
      default: emit = 1'b0;
    endcase
  end

  assign q_push_o = accept && emit;

  // Shadow registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_bits_q  <= '0;
      ctrl_bits_q  <= '0;
      entry_bits_q <= '0;
      rows_use_q   <= '0;
      cols_lat_q   <= '0;
    end else if (accept) begin
      func_bits_q  <= func_bits_d;
      ctrl_bits_q  <= ctrl_bits_d;
      entry_bits_q <= entry_bits_d;
      rows_use_q   <= rows_use_d;
      cols_lat_q   <= cols_lat_d;
    end
  end

endmodule

@@ design/clcd_desc_fifo.sv @@
// Short command queue between the front end and the transfer sequencer.
`timescale 1ns / 1ps

module clcd_desc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  clcd_pkg::desc_t desc_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output clcd_pkg::desc_t desc_o
);
  import clcd_pkg::*;

  desc_t                entry_q [DescDepth];
  logic [DescPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [DescCntW-1:0]  count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == DescCntW'(DescDepth));
  assign valid_o = (count_q != '0);
  assign desc_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + DescCntW'(do_push) - DescCntW'(do_pop);
    end
  end

endmodule

@@ design/clcd_back.sv @@
// Back end: expands queued commands into bus transfers and buffers them.
`timescale 1ns / 1ps

module clcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            desc_valid_i,
  input  clcd_pkg::desc_t desc_i,
  output logic            desc_pop_o,
  input  logic            pop,
  output logic            empty,
  output clcd_pkg::xfer_t xfer_o
);
  import clcd_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic [2:0] slot_q, slot_d;
  logic       half_q, half_d;

  logic [2:0] cur_slot;
  logic       cur_half;
  logic       wake;
  logic       one_xfer;
  logic       byte_done;
  logic [7:0] bus_byte;
  logic [1:0] byte_pause;
  logic       fire;
  xfer_t      xfer;

  xfer_t      obuf_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q;
  logic       ofull;
  logic       opop;

  // Position within the current command
  assign cur_slot = (state_q == SEQ_RUN) ? slot_q
                  : (desc_i.is_init ? SlotWake0 : SlotLast);
  assign cur_half = (state_q == SEQ_RUN) ? half_q : 1'b0;
  assign wake     = desc_i.is_init && !cur_slot[2];
  assign one_xfer = wake || desc_i.bus8;
  assign byte_done = one_xfer || cur_half;

  // Byte and pause for the current slot
  always_comb begin
    bus_byte   = desc_i.bus_byte;
    byte_pause = desc_i.pause;
    if (desc_i.is_init) begin
      case (cur_slot)
        SlotWake0, SlotWake1: begin
          bus_byte   = WakeByte;
          byte_pause = Pause5ms;
        end
        SlotWake2: begin
          bus_byte   = WakeByte;
          byte_pause = Pause1ms;
        end
        SlotWakeLast: begin
          bus_byte   = desc_i.bus8 ? WakeByte : WakeLast;
          byte_pause = PauseNone;
        end
        SlotFuncSet: begin
          bus_byte   = desc_i.bus_byte;
          byte_pause = PauseNone;
        end
        SlotDisplay: begin
          bus_byte   = InitDisplay;
          byte_pause = PauseNone;
        end
        SlotClear: begin
          bus_byte   = CmdClear;
          byte_pause = Pause2ms;
        end
        default: begin
          bus_byte   = InitEntry;
          byte_pause = PauseNone;
        end
      endcase
    end
  end

  // Transfer built from the byte: whole, or one nibble in bits 7..4
  always_comb begin
    xfer.rs = desc_i.rs;
    if (one_xfer) begin
      xfer.value = bus_byte;
    end else if (!cur_half) begin
      xfer.value = {bus_byte[7:4], 4'b0000};
    end else begin
      xfer.value = {bus_byte[3:0], 4'b0000};
    end
    xfer.pause_before = desc_i.is_init && (cur_slot == SlotWake0);
    xfer.pause_after  = byte_done ? byte_pause : PauseNone;
    xfer.last         = byte_done && (cur_slot == SlotLast);
  end

  assign ofull      = (ocnt_q == 2'd2);
  assign fire       = desc_valid_i && !ofull;
  assign desc_pop_o = fire && xfer.last;

  // Sequencer
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    half_d  = half_q;
    if (fire) begin
      if (xfer.last) begin
        state_d = SEQ_IDLE;
      end else if (byte_done) begin
        state_d = SEQ_RUN;
        slot_d  = cur_slot + 3'd1;
        half_d  = 1'b0;
      end else begin
        state_d = SEQ_RUN;
        slot_d  = cur_slot;
        half_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      slot_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      half_q  <= half_d;
    end
  end

  // Two-entry result buffer
  assign empty  = (ocnt_q == 2'd0);
  assign xfer_o = obuf_q[ord_q];
  assign opop   = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      obuf_q[owr_q] <= xfer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (fire) begin
        owr_q <= ~owr_q;
      end
      if (opop) begin
        ord_q <= ~ord_q;
      end
      ocnt_q <= ocnt_q + 2'(fire) - 2'(opop);
    end
  end

  // A command in progress keeps its queue entry until its final transfer
  a_run_has_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> desc_valid_i)
    else $error("sequencer running without a queued command");

  // A transfer that is not final leaves the sequencer mid-command
  a_not_last_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !xfer.last) |=> (state_q == SEQ_RUN))
    else $error("sequencer dropped out mid-command");

  // Result buffer never overfills
  a_obuf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 2'd2)
    else $error("result buffer overflow");

  // The second nibble of a byte always follows its first
  a_nibble_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !one_xfer && !cur_half) |=> (half_q && (slot_q == $past(cur_slot))))
    else $error("nibble pair broken");

endmodule

@@ bench/testbench.sv @@
// Testbench for the character-LCD command sequencer core.
`timescale 1ns / 1ps

module testbench;
  import clcd_pkg::*;

  // Longest run of cycles without a transaction before the run is declared hung
  localparam int unsigned StallLimit   = 2000;
  // Cycles allowed for items that produce no transfer to clear the pipeline
  localparam int unsigned SettleCycles = 8;
  // Length of the long receiver hold-off
  localparam int unsigned HoldCycles   = 400;

  // Func codes past the character code produce nothing
  localparam logic [4:0] FnUnusedFirst = FnChar + 5'd1;
  localparam logic [4:0] FnUnusedLast  = 5'h1F;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_index_i   = CfgColumns;
  logic [5:0] cfg_data_i    = '0;
  logic       push          = 1'b0;
  logic [4:0] func_i        = FnInit;
  logic [7:0] char_or_col_i = '0;
  logic [7:0] row_number_i  = '0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic       reg_select_o;
  logic [7:0] bus_value_o;
  logic       pause_before_o;
  logic [1:0] pause_after_o;
  logic       last_transfer_o;

  char_lcd_command_sequencer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .char_or_col_i  (char_or_col_i),
    .row_number_i   (row_number_i),
    .empty          (empty),
    .pop            (pop),
    .reg_select_o   (reg_select_o),
    .bus_value_o    (bus_value_o),
    .pause_before_o (pause_before_o),
    .pause_after_o  (pause_after_o),
    .last_transfer_o(last_transfer_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copies as last written
  logic [5:0] columns_reg = ColumnsReset;
  logic [2:0] rows_reg    = RowsReset;
  logic       tall_reg    = 1'b0;
  logic       bus8_reg    = 1'b0;

  // Shadow of the display state held by the sequencer
  logic [1:0] func_bits  = '0;
  logic [2:0] ctrl_bits  = '0;
  logic [1:0] entry_mode = '0;
  logic [2:0] rows_used  = '0;
  logic [5:0] cols_used  = '0;

  xfer_t expected_xfers[$];
  xfer_t run_xfers[$];

  int mismatch_count = 0;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_request   = 0;
  int hold_left      = 0;
  int rx_gap         = 0;
  int stall_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Transfer prediction
  // ---------------------------------------------------------------------------

  function automatic void add_xfer(logic rs, logic [7:0] val, logic pb, logic [1:0] pa);
    xfer_t x;
    x.rs           = rs;
    x.value        = val;
    x.pause_before = pb;
    x.pause_after  = pa;
    x.last         = 1'b0;
    run_xfers.push_back(x);
  endfunction

  // A byte goes whole on the wide bus, else as two nibbles, high one first
  function automatic void add_byte(logic rs, logic [7:0] b, logic [1:0] pa);
    if (bus8_reg) begin
      add_xfer(rs, b, 1'b0, pa);
    end else begin
      add_xfer(rs, {b[7:4], 4'h0}, 1'b0, PauseNone);
      add_xfer(rs, {b[3:0], 4'h0}, 1'b0, pa);
    end
  endfunction

  // Wake-up strobe: single nibble on the narrow bus, full wake byte on the wide one
  function automatic void add_wake(logic [3:0] nib, logic pb, logic [1:0] pa);
    if (bus8_reg) begin
      add_xfer(1'b0, WakeByte, pb, pa);
    end else begin
      add_xfer(1'b0, {nib, 4'h0}, pb, pa);
    end
  endfunction

  function automatic void predict_transfers(logic [4:0] f, logic [7:0] cc, logic [7:0] rn);
    xfer_t      x;
    logic [7:0] fs;
    int         row;
    int         offset;
    run_xfers.delete();
    case (f)
      FnInit: begin
        // two-line and tall-font bits are sticky: init only sets them
        if (rows_reg > 3'd1) func_bits[1] = 1'b1;
        if (tall_reg && rows_reg == 3'd1) func_bits[0] = 1'b1;
        rows_used = rows_reg;
        cols_used = columns_reg;
        add_wake(4'h3, 1'b1, Pause5ms);
        add_wake(4'h3, 1'b0, Pause5ms);
        add_wake(4'h3, 1'b0, Pause1ms);
        add_wake(4'h2, 1'b0, PauseNone);
        fs = CmdFuncSet | (bus8_reg ? Func8Bit : 8'h00) | {4'h0, func_bits, 2'b00};
        add_byte(1'b0, fs, PauseNone);
        ctrl_bits = 3'b100;
        add_byte(1'b0, CmdControl | {5'b0, ctrl_bits}, PauseNone);
        add_byte(1'b0, CmdClear, Pause2ms);
        entry_mode = 2'b10;
        add_byte(1'b0, CmdEntry | {6'b0, entry_mode}, PauseNone);
      end
      FnClear: add_byte(1'b0, CmdClear, Pause2ms);
      FnHome:  add_byte(1'b0, CmdHome, Pause2ms);
      FnCursorPos: begin
        // clamp to the last physical row, then to the rows latched at init
        row = (rn > 8'd3) ? 3 : int'(rn);
        if (rows_used == 3'd0) row = 0;
        else if (row >= int'(rows_used)) row = int'(rows_used) - 1;
        case (row)
          0:       offset = 0;
          1:       offset = 'h40;
          2:       offset = int'(cols_used);
          default: offset = 'h40 + int'(cols_used);
        endcase
        add_byte(1'b0, CmdDdram | 8'((int'(cc) + offset) % 128), PauseNone);
      end
      FnDispOn, FnDispOff, FnCursorOn, FnCursorOff, FnBlinkOn, FnBlinkOff: begin
        case (f)
          FnDispOn:    ctrl_bits[2] = 1'b1;
          FnDispOff:   ctrl_bits[2] = 1'b0;
          FnCursorOn:  ctrl_bits[1] = 1'b1;
          FnCursorOff: ctrl_bits[1] = 1'b0;
          FnBlinkOn:   ctrl_bits[0] = 1'b1;
          default:     ctrl_bits[0] = 1'b0;
        endcase
        add_byte(1'b0, CmdControl | {5'b0, ctrl_bits}, PauseNone);
      end
      FnScrollL: add_byte(1'b0, CmdScrollL, PauseNone);
      FnScrollR: add_byte(1'b0, CmdScrollR, PauseNone);
      FnLtoR, FnRtoL, FnAutoOn, FnAutoOff: begin
        case (f)
          FnLtoR:   entry_mode[1] = 1'b1;
          FnRtoL:   entry_mode[1] = 1'b0;
          FnAutoOn: entry_mode[0] = 1'b1;
          default:  entry_mode[0] = 1'b0;
        endcase
        add_byte(1'b0, CmdEntry | {6'b0, entry_mode}, PauseNone);
      end
      FnChar:  add_byte(1'b1, cc, PauseNone);
      default: ;
    endcase
    // flag the final transfer of the run
    foreach (run_xfers[i]) begin
      x      = run_xfers[i];
      x.last = (i == run_xfers.size() - 1);
      expected_xfers.push_back(x);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // push is left high after a transaction so back-to-back items need no gap
  task automatic send_item(input logic [4:0] f, input logic [7:0] cc, input logic [7:0] rn);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    func_i        <= f;
    char_or_col_i <= cc;
    row_number_i  <= rn;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_transfers(f, cc, rn);
  endtask

  // Mostly well-formed commands and characters, with some init and unused codes
  task automatic send_random_item();
    int         pick;
    logic [4:0] f;
    logic [7:0] rn;
    pick = $urandom_range(0, 99);
    if (pick < 40) f = FnChar;
    else if (pick < 55) f = FnCursorPos;
    else if (pick < 88) f = 5'($urandom_range(FnClear, FnAutoOff));
    else if (pick < 91) f = FnInit;
    else f = 5'($urandom_range(FnUnusedFirst, FnUnusedLast));
    rn = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
    send_item(f, 8'($urandom_range(0, 255)), rn);
  endtask

  // Stop sending, let every expected transfer arrive, then let the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_xfers.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CfgColumns:  columns_reg = data;
      CfgRows:     rows_reg    = data[2:0];
      CfgTallFont: tall_reg    = data[0];
      default:     bus8_reg    = data[0];
    endcase
  endtask

  // Only called with the block idle
  task automatic apply_config(input int cols, input int rows, input bit tall, input bit bus8);
    write_reg(CfgColumns, 6'(cols));
    write_reg(CfgRows, 6'(rows));
    write_reg(CfgTallFont, 6'(tall));
    write_reg(CfgBus8, 6'(bus8));
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command and the corner cases, on the reset configuration
  task automatic test_directed();
    // set-cursor before any init: no rows latched, so row 0 and a zero offset
    send_item(FnCursorPos, 8'hFF, 8'hFF);
    send_item(FnChar, 8'h00, 8'h00);
    send_item(FnChar, 8'hFF, 8'hFF);
    send_item(FnInit, 8'h00, 8'h00);
    for (int i = FnClear; i <= FnAutoOff; i++) begin
      send_item(5'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    // row above the latched rows is clamped
    send_item(FnCursorPos, 8'h00, 8'h00);
    send_item(FnCursorPos, 8'hFF, 8'h03);
    send_item(FnCursorPos, 8'd39, 8'h01);
    send_item(FnUnusedFirst, 8'hA5, 8'h5A);
    send_item(FnUnusedLast, 8'hFF, 8'hFF);
    wait_drained();
  endtask

  // Several settings including the extremes, each followed by init and random traffic
  task automatic test_config_sweep();
    int cols_set[6] = '{40, 1, 33, 1, 7, 40};
    int rows_set[6] = '{4, 1, 3, 1, 2, 4};
    bit tall_set[6] = '{0, 1, 1, 1, 0, 1};
    bit bus_set[6]  = '{1, 0, 0, 1, 1, 0};
    for (int s = 0; s < 6; s++) begin
      apply_config(cols_set[s], rows_set[s], tall_set[s], bus_set[s]);
      send_item(FnInit, 8'h00, 8'h00);
      repeat (54) send_random_item();
      wait_drained();
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    sender_idles = 1'b0;
    hold_request = HoldCycles;
    repeat (40) send_random_item();
    sender_idles = 1'b1;
    wait_drained();
  endtask

  // Closing stretch with no idling on either side
  task automatic test_steady_stream();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    apply_config($urandom_range(1, 40), $urandom_range(1, 4), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    send_item(FnInit, 8'h00, 8'h00);
    repeat (60) send_random_item();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and receiver flow control
  // ---------------------------------------------------------------------------

  task automatic report_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 50)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    xfer_t want;
    // compare each transaction against the oldest expected transfer
    if (rst_ni && pop && !empty) begin
      if (expected_xfers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 50)
          $display("%0t: unexpected transfer: expected none, actual rs=%0b bus=%02h last=%0b",
                   $time, reg_select_o, bus_value_o, last_transfer_o);
      end else begin
        want = expected_xfers.pop_front();
        report_field("reg_select", 8'(want.rs), 8'(reg_select_o));
        report_field("bus_value", want.value, bus_value_o);
        report_field("pause_before", 8'(want.pause_before), 8'(pause_before_o));
        report_field("pause_after", 8'(want.pause_after), 8'(pause_after_o));
        report_field("last_transfer", 8'(want.last), 8'(last_transfer_o));
      end
    end
    // pop: long hold when asked for, otherwise random-length bursts of idle cycles
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      pop <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 7);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: too long without any transaction means the block has hung
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_steady_stream();
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ char_lcd_command_sequencer_core.f @@
design/clcd_pkg.sv
design/clcd_front.sv
design/clcd_desc_fifo.sv
design/clcd_back.sv
design/char_lcd_command_sequencer_core.sv
bench/testbench.sv
